### rtl/abvs_pkg.sv
// Package for the accelerating button value stepper.
// Holds widths, event and register codes and the stage table lookups.
// No dependencies.
package abvs_pkg;

    localparam int NUM_STAGES   = 3;
    localparam int STAGE_W      = 2;
    localparam int VALUE_W      = 16;
    localparam int TIME_W       = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [STAGE_W-1:0] STAGE_FIRST = '0;
    localparam logic [STAGE_W-1:0] STAGE_LAST  = STAGE_W'(NUM_STAGES - 1);

    // Button event codes; the unused code acts as idle.
    localparam logic [1:0] EV_PRESSED = 2'd0;
    localparam logic [1:0] EV_HELD    = 2'd1;
    localparam logic [1:0] EV_IDLE    = 2'd2;

    // Direction codes.
    localparam logic DIR_UP   = 1'b0;
    localparam logic DIR_DOWN = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_FLOOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_CEIL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TIME_0 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_TIME_1 = 3'd7;

    typedef struct packed {
        logic [VALUE_W-1:0] value_floor;
        logic [VALUE_W-1:0] value_ceil;
        logic [VALUE_W-1:0] repeat_interval_ms;
        logic [VALUE_W-1:0] step_size_0;
        logic [VALUE_W-1:0] step_size_1;
        logic [VALUE_W-1:0] step_size_2;
        logic [VALUE_W-1:0] stage_time_0;
        logic [VALUE_W-1:0] stage_time_1;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        value_floor:        16'd0,
        value_ceil:         16'd1000,
        repeat_interval_ms: 16'd100,
        step_size_0:        16'd1,
        step_size_1:        16'd10,
        step_size_2:        16'd100,
        stage_time_0:       16'd1000,
        stage_time_1:       16'd2000
    };

    // Step amount of a stage; stages past the table use the last entry.
    function automatic logic [VALUE_W-1:0] stage_step(input t_cfg cfg,
                                                      input logic [STAGE_W-1:0] idx);
        logic [VALUE_W-1:0] s;
        if (idx == 2'd0) begin
            s = cfg.step_size_0;
        end else if (idx == 2'd1) begin
            s = cfg.step_size_1;
        end else begin
            s = cfg.step_size_2;
        end
        return s;
    endfunction

    // Hold time of a stage; every stage past the first uses stage_time_1.
    function automatic logic [VALUE_W-1:0] stage_hold(input t_cfg cfg,
                                                      input logic [STAGE_W-1:0] idx);
        logic [VALUE_W-1:0] h;
        if (idx == STAGE_FIRST) begin
            h = cfg.stage_time_0;
        end else begin
            h = cfg.stage_time_1;
        end
        return h;
    endfunction

endpackage

### rtl/abvs_if.sv
// Handshake channel interfaces for the accelerating button value stepper.
// Depends on abvs_pkg for field widths.
interface abvs_in_if
    import abvs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              opcode;
    logic [1:0]        button_event;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output opcode, output button_event, output now_ms,
                    input ready);
    modport sink   (input valid, input opcode, input button_event, input now_ms,
                    output ready);
endinterface

interface abvs_out_if
    import abvs_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] current_value;
    logic               changed;
    logic               change_direction;

    modport source (output valid, output current_value, output changed,
                    output change_direction, input ready);
    modport sink   (input valid, input current_value, input changed,
                    input change_direction, output ready);
endinterface

interface abvs_cfg_if
    import abvs_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/accelerating_button_value_stepper.sv
// Top level of the accelerating button value stepper.
// Depends on abvs_pkg and the channel interfaces in abvs_if.sv.
//
// Each transfer on i_in is one button event (direction, pressed/held/idle, millisecond
// time) and yields exactly one transfer on o_out carrying the value after the event,
// whether it changed and in which direction. A press restarts acceleration at stage 0
// and steps at once; while held, the stage advances after its hold time since the press
// and a repeat step fires once the repeat interval has passed since the last step. The
// value saturates at the floor and ceiling registers; time differences wrap modulo 2^32.
// An event is captured in the input register, then evaluated and written to the output
// register, which drives o_out. The block takes one event per cycle, limited only by
// the sink's ready. Configuration writes on i_cfg are always taken (ready tied high)
// and must be issued only while no event is in flight.
module accelerating_button_value_stepper
    import abvs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    abvs_in_if.sink       i_in,
    abvs_out_if.source    o_out,
    abvs_cfg_if.sink      i_cfg
);

    // Configuration registers.
    t_cfg r_cfg;

    // Input register.
    logic              r_in_valid;
    logic              r_in_opcode;
    logic [1:0]        r_in_event;
    logic [TIME_W-1:0] r_in_now;

    // Stepper state.
    logic [VALUE_W-1:0] r_value,      n_value;
    logic [STAGE_W-1:0] r_stage,      n_stage;
    logic [TIME_W-1:0]  r_press_time, n_press_time;
    logic [TIME_W-1:0]  r_last_time,  n_last_time;

    // Output register.
    logic               r_out_valid;
    logic [VALUE_W-1:0] r_out_value;
    logic               r_out_changed;
    logic               r_out_dir;

    logic               w_adv;
    logic               w_pressed;
    logic               w_held;
    logic               w_fire;
    logic [STAGE_W-1:0] w_stage_adv;
    logic [TIME_W-1:0]  w_since_press;
    logic [TIME_W-1:0]  w_since_last;
    logic [VALUE_W-1:0] w_step;
    logic [VALUE_W:0]   w_sum;
    logic [VALUE_W-1:0] w_diff;

    // Advance the input register into the output register when the output is
    // empty or being drained this cycle.
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_out_valid;
    assign o_out.current_value    = r_out_value;
    assign o_out.changed          = r_out_changed;
    assign o_out.change_direction = r_out_dir;

    // Event evaluation.
    always_comb begin
        w_pressed     = (r_in_event == EV_PRESSED);
        w_held        = (r_in_event == EV_HELD);
        w_since_press = r_in_now - r_press_time;
        w_since_last  = r_in_now - r_last_time;

        // Stage advance while held, strictly after the stage's hold time.
        w_stage_adv = r_stage;
        if (w_held && (r_stage < STAGE_LAST) &&
            (w_since_press > {{(TIME_W-VALUE_W){1'b0}}, stage_hold(r_cfg, r_stage)})) begin
            w_stage_adv = r_stage + STAGE_W'(1);
        end

        w_fire = w_pressed ||
                 (w_held && (w_since_last >
                             {{(TIME_W-VALUE_W){1'b0}}, r_cfg.repeat_interval_ms}));

        n_stage      = w_stage_adv;
        n_press_time = r_press_time;
        n_last_time  = r_last_time;
        n_value      = r_value;
        if (w_pressed) begin
            n_stage      = STAGE_FIRST;
            n_press_time = r_in_now;
        end

        w_step = stage_step(r_cfg, n_stage);
        w_sum  = {1'b0, r_value} + {1'b0, w_step};
        w_diff = r_value - w_step;

        if (w_fire) begin
            n_last_time = r_in_now;
            if (r_in_opcode == DIR_UP) begin
                // Saturate at the ceiling; a value already at or above it holds.
                if (w_sum < {1'b0, r_cfg.value_ceil}) begin
                    n_value = w_sum[VALUE_W-1:0];
                end else if (r_value < r_cfg.value_ceil) begin
                    n_value = r_cfg.value_ceil;
                end
            end else begin
                // Saturate at the floor; a difference at or below zero never beats it.
                if ((r_value > w_step) && (w_diff > r_cfg.value_floor)) begin
                    n_value = w_diff;
                end else if (r_value > r_cfg.value_floor) begin
                    n_value = r_cfg.value_floor;
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_VALUE_FLOOR:  r_cfg.value_floor        <= i_cfg.data;
                REG_VALUE_CEIL:   r_cfg.value_ceil         <= i_cfg.data;
                REG_REPEAT_MS:    r_cfg.repeat_interval_ms <= i_cfg.data;
                REG_STEP_SIZE_0:  r_cfg.step_size_0        <= i_cfg.data;
                REG_STEP_SIZE_1:  r_cfg.step_size_1        <= i_cfg.data;
                REG_STEP_SIZE_2:  r_cfg.step_size_2        <= i_cfg.data;
                REG_STAGE_TIME_0: r_cfg.stage_time_0       <= i_cfg.data;
                REG_STAGE_TIME_1: r_cfg.stage_time_1       <= i_cfg.data;
            endcase
        end
    end

    // Input register: capture on every input transfer, drop when advanced.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_opcode <= i_in.opcode;
            r_in_event  <= i_in.button_event;
            r_in_now    <= i_in.now_ms;
        end
    end

    // Stepper state: commit only when the event moves to the output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value      <= '0;
            r_stage      <= STAGE_FIRST;
            r_press_time <= '0;
            r_last_time  <= '0;
        end else if (w_adv) begin
            r_value      <= n_value;
            r_stage      <= n_stage;
            r_press_time <= n_press_time;
            r_last_time  <= n_last_time;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_value   <= n_value;
            r_out_changed <= (n_value != r_value);
            r_out_dir     <= (n_value != r_value) ? r_in_opcode : DIR_UP;
        end
    end

    // The stage never runs past the last table stage.
    a_stage_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage <= STAGE_LAST)
        else $error("stage index beyond last stage");

    // A press restarts the stage and records the press time.
    a_press_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_pressed) |=> (r_stage == STAGE_FIRST) && (r_press_time == $past(r_in_now)))
        else $error("press did not restart acceleration");

    // The changed flag tracks the stored value.
    a_changed_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> ((r_value != $past(r_value)) == r_out_changed) && (r_out_value == r_value))
        else $error("changed flag disagrees with stored value");

    // Without a step attempt, hold the value and the last step time.
    a_no_fire_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !w_fire) |=> $stable(r_value) && $stable(r_last_time))
        else $error("value moved without a step");

    // An unchanged result reports direction zero.
    a_dir_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_changed) |-> (r_out_dir == DIR_UP))
        else $error("direction set without a change");

endmodule
